// ----- hdl/glc_pkg.sv -----
// Shared widths and types for the gate line crossing counter.
`timescale 1ns / 1ps
`default_nettype none
package glc_pkg;
	localparam int COORD_BITS     = 12;
	localparam int COUNT_BITS     = 24;
	localparam int FRAME_BITS     = 16;
	localparam int FIU_BITS       = 17;
	localparam int CFG_IDX_BITS   = 3;
	localparam int CFG_DATA_BITS  = 17;
	localparam int MAX_FRAMES_DEF = 65536;

	localparam int DIFF_BITS = COORD_BITS + 1;
	localparam int PROD_BITS = 2 * DIFF_BITS;
	localparam int NUM_BITS  = PROD_BITS + 1;

	typedef struct packed {
		logic valid;
		logic hit;
	} meet_res_t;
endpackage
`default_nettype wire

// ----- hdl/glc_meet.sv -----
// Three-stage segment versus gate intersection test in exact integers.
`timescale 1ns / 1ps
`default_nettype none
module glc_meet
	import glc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  go,
	input  wire logic [COORD_BITS-1:0] gate_x0,
	input  wire logic [COORD_BITS-1:0] gate_y0,
	input  wire logic [COORD_BITS-1:0] gate_x1,
	input  wire logic [COORD_BITS-1:0] gate_y1,
	input  wire logic [COORD_BITS-1:0] seg_x0,
	input  wire logic [COORD_BITS-1:0] seg_y0,
	input  wire logic [COORD_BITS-1:0] seg_x1,
	input  wire logic [COORD_BITS-1:0] seg_y1,
	output meet_res_t                  res
);
	logic signed [DIFF_BITS-1:0] ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1;
	logic signed [PROD_BITS-1:0] aybx_s2, axby_s2, bycx_s2, bxcy_s2, axcy_s2, aycx_s2;
	logic signed [NUM_BITS-1:0]  d_c, na_c, nb_c;
	logic                        v_s1, v_s2;

	function automatic logic in_unit(input logic signed [NUM_BITS-1:0] n,
			input logic signed [NUM_BITS-1:0] d);
		logic r;
		if (d > 0)
			r = (n >= 0) && (n <= d);
		else
			r = (n <= 0) && (n >= d);
		return r;
	endfunction

	function automatic logic signed [NUM_BITS-1:0] sext(input logic signed [PROD_BITS-1:0] p);
		return {p[PROD_BITS-1], p};
	endfunction

	always_ff @(posedge clk) begin
		ax_s1 <= $signed({1'b0, gate_x1}) - $signed({1'b0, gate_x0});
		ay_s1 <= $signed({1'b0, gate_y1}) - $signed({1'b0, gate_y0});
		bx_s1 <= $signed({1'b0, seg_x0}) - $signed({1'b0, seg_x1});
		by_s1 <= $signed({1'b0, seg_y0}) - $signed({1'b0, seg_y1});
		cx_s1 <= $signed({1'b0, gate_x0}) - $signed({1'b0, seg_x0});
		cy_s1 <= $signed({1'b0, gate_y0}) - $signed({1'b0, seg_y0});
		aybx_s2 <= ay_s1 * bx_s1;
		axby_s2 <= ax_s1 * by_s1;
		bycx_s2 <= by_s1 * cx_s1;
		bxcy_s2 <= bx_s1 * cy_s1;
		axcy_s2 <= ax_s1 * cy_s1;
		aycx_s2 <= ay_s1 * cx_s1;
	end

	assign d_c  = sext(aybx_s2) - sext(axby_s2);
	assign na_c = sext(bycx_s2) - sext(bxcy_s2);
	assign nb_c = sext(axcy_s2) - sext(aycx_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			res.valid <= 1'b0;
			res.hit   <= 1'b0;
		end else begin
			v_s1      <= go;
			v_s2      <= v_s1;
			res.valid <= v_s2;
			// parallel or degenerate segments never meet
			res.hit   <= (d_c != 0) && in_unit(na_c, d_c) && in_unit(nb_c, d_c);
		end
	end
endmodule
`default_nettype wire

// ----- hdl/gate_line_crossing_counter.sv -----
// Top level: command sequencer around the per-frame count memory.
// Steps: clear zeroes every entry; segment runs the intersection test, then updates its
// entry if counted in range; query reads one entry; build sums the used entries in turn.
// One request at a time; busy is high from accept until the result cycle, so the next
// request can be accepted in the cycle done is high. The count memory (one read and one
// write port) serves the read-modify-write and the walks over its entries.
// After reset the table is swept to zero with busy high.
// The receiver cannot stall: done marks each result for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module gate_line_crossing_counter
	import glc_pkg::*;
#(
	parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [1:0]               action,
	input  wire logic [FRAME_BITS-1:0]    seg_frame,
	input  wire logic [COORD_BITS-1:0]    seg_x0,
	input  wire logic [COORD_BITS-1:0]    seg_y0,
	input  wire logic [COORD_BITS-1:0]    seg_x1,
	input  wire logic [COORD_BITS-1:0]    seg_y1,
	input  wire logic                     last_segment,
	input  wire logic [FRAME_BITS-1:0]    query_frame,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
	output logic                          done,
	output logic                          crossed,
	output logic [FRAME_BITS-1:0]         crossing_frame,
	output logic [COUNT_BITS-1:0]         cumulative_count,
	output logic                          query_valid,
	output logic                          bad_frame,
	output logic [COUNT_BITS-1:0]         total_vehicles
);
	localparam int AW = $clog2(MAX_FRAMES);
	localparam int UW = $clog2(MAX_FRAMES + 1);
	localparam int CW = (UW > FIU_BITS) ? UW : FIU_BITS;

	localparam logic [1:0] ACT_CLEAR   = 2'd0;
	localparam logic [1:0] ACT_SEGMENT = 2'd1;
	localparam logic [1:0] ACT_BUILD   = 2'd2;
	localparam logic [1:0] ACT_QUERY   = 2'd3;

	localparam logic [CFG_IDX_BITS-1:0] CFG_GATE_X0 = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GATE_Y0 = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GATE_X1 = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GATE_Y1 = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FRAMES  = 3'd4;

	localparam logic [AW-1:0]         LAST_ADDR = AW'(MAX_FRAMES - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_MEET, S_SEG_WR, S_QRY_RD, S_QRY_DATA, S_BUILD, S_BUILD_TAIL
	} state_t;

	state_t                   state_q;
	logic [COORD_BITS-1:0]    gx0_q, gy0_q, gx1_q, gy1_q;
	logic [FIU_BITS-1:0]      fiu_q;
	logic [FRAME_BITS-1:0]    frame_q, query_q;
	logic                     last_q, qv_q, report_q, counted_q;
	logic [COUNT_BITS-1:0]    total_q, run_q;
	logic [AW-1:0]            clr_idx_q, bld_idx_q, bidx_s1;
	logic                     bvalid_s1;

	logic [COUNT_BITS-1:0]    mem [MAX_FRAMES];
	logic [COUNT_BITS-1:0]    rd_data_s1;
	logic                     mem_re, mem_we;
	logic [AW-1:0]            mem_ra, mem_wa;
	logic [COUNT_BITS-1:0]    mem_wd;

	meet_res_t                meet_res;
	logic                     meet_go, accept, hit_c, frame_ok_c;
	logic [CW-1:0]            used_c, used_m1_c, fext_c, qext_c, qport_c;
	logic [AW-1:0]            frame_addr_c, query_addr_c;
	logic [COUNT_BITS:0]      tot_sum_c, inc_sum_c, run_sum_c;
	logic [COUNT_BITS-1:0]    tot_inc_c, inc_c, run_c;

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign meet_go = accept && (action == ACT_SEGMENT);

	glc_meet u_meet (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (meet_go),
		.gate_x0 (gx0_q),
		.gate_y0 (gy0_q),
		.gate_x1 (gx1_q),
		.gate_y1 (gy1_q),
		.seg_x0  (seg_x0),
		.seg_y0  (seg_y0),
		.seg_x1  (seg_x1),
		.seg_y1  (seg_y1),
		.res     (meet_res)
	);

	always_comb begin
		used_c       = (CW'(fiu_q) > CW'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(fiu_q);
		used_m1_c    = used_c - CW'(1);
		fext_c       = CW'(frame_q);
		qext_c       = CW'(query_q);
		qport_c      = CW'(query_frame);
		frame_addr_c = fext_c[AW-1:0];
		query_addr_c = qext_c[AW-1:0];
		frame_ok_c   = (fext_c < used_c);
		hit_c        = meet_res.hit && !counted_q;
		tot_sum_c    = {1'b0, total_q} + (COUNT_BITS+1)'(1);
		tot_inc_c    = tot_sum_c[COUNT_BITS] ? COUNT_MAX : tot_sum_c[COUNT_BITS-1:0];
		inc_sum_c    = {1'b0, rd_data_s1} + (COUNT_BITS+1)'(1);
		inc_c        = inc_sum_c[COUNT_BITS] ? COUNT_MAX : inc_sum_c[COUNT_BITS-1:0];
		run_sum_c    = {1'b0, run_q} + {1'b0, rd_data_s1};
		if (bidx_s1 == '0)
			run_c = rd_data_s1;
		else
			run_c = run_sum_c[COUNT_BITS] ? COUNT_MAX : run_sum_c[COUNT_BITS-1:0];
	end

	// memory port control
	always_comb begin
		mem_re = 1'b0;
		mem_ra = '0;
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_idx_q;
			end
			S_MEET: begin
				mem_re = meet_res.valid && hit_c && frame_ok_c;
				mem_ra = frame_addr_c;
			end
			S_SEG_WR: begin
				mem_we = 1'b1;
				mem_wa = frame_addr_c;
				mem_wd = inc_c;
			end
			S_QRY_RD: begin
				mem_re = qv_q;
				mem_ra = query_addr_c;
			end
			S_BUILD, S_BUILD_TAIL: begin
				mem_re = (state_q == S_BUILD);
				mem_ra = bld_idx_q;
				mem_we = bvalid_s1 && (bidx_s1 != '0);
				mem_wa = bidx_s1;
				mem_wd = run_c;
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			rd_data_s1 <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gx0_q <= '0;
			gy0_q <= '0;
			gx1_q <= '0;
			gy1_q <= '0;
			fiu_q <= FIU_BITS'(65536);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GATE_X0: gx0_q <= cfg_data[COORD_BITS-1:0];
				CFG_GATE_Y0: gy0_q <= cfg_data[COORD_BITS-1:0];
				CFG_GATE_X1: gx1_q <= cfg_data[COORD_BITS-1:0];
				CFG_GATE_Y1: gy1_q <= cfg_data[COORD_BITS-1:0];
				CFG_FRAMES:  fiu_q <= cfg_data[FIU_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			frame_q <= seg_frame;
			query_q <= query_frame;
			last_q  <= last_segment;
		end
		bidx_s1 <= bld_idx_q;
		if (bvalid_s1)
			run_q <= run_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_CLEAR;
			clr_idx_q        <= '0;
			bld_idx_q        <= '0;
			bvalid_s1        <= 1'b0;
			report_q         <= 1'b0;
			qv_q             <= 1'b0;
			counted_q        <= 1'b0;
			total_q          <= '0;
			done             <= 1'b0;
			crossed          <= 1'b0;
			crossing_frame   <= '0;
			cumulative_count <= '0;
			query_valid      <= 1'b0;
			bad_frame        <= 1'b0;
			total_vehicles   <= '0;
		end else begin
			done      <= 1'b0;
			bvalid_s1 <= (state_q == S_BUILD);
			case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + AW'(1);
					if (clr_idx_q == LAST_ADDR) begin
						state_q          <= S_IDLE;
						done             <= report_q;
						crossed          <= 1'b0;
						crossing_frame   <= '0;
						cumulative_count <= '0;
						query_valid      <= 1'b0;
						bad_frame        <= 1'b0;
						total_vehicles   <= total_q;
					end
				end
				S_IDLE: begin
					if (start) begin
						case (action)
							ACT_CLEAR: begin
								clr_idx_q <= '0;
								report_q  <= 1'b1;
								total_q   <= '0;
								counted_q <= 1'b0;
								state_q   <= S_CLEAR;
							end
							ACT_SEGMENT: state_q <= S_MEET;
							ACT_BUILD: begin
								bld_idx_q <= '0;
								if (used_c == '0) begin
									// empty table: report like an invalid query
									qv_q    <= 1'b0;
									state_q <= S_QRY_RD;
								end else begin
									state_q <= S_BUILD;
								end
							end
							ACT_QUERY: begin
								qv_q    <= (qport_c < used_c);
								state_q <= S_QRY_RD;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_MEET: begin
					if (meet_res.valid) begin
						if (last_q)
							counted_q <= 1'b0;
						else if (hit_c)
							counted_q <= 1'b1;
						if (hit_c)
							total_q <= tot_inc_c;
						if (hit_c && frame_ok_c) begin
							state_q <= S_SEG_WR;
						end else begin
							state_q          <= S_IDLE;
							done             <= 1'b1;
							crossed          <= hit_c;
							crossing_frame   <= hit_c ? frame_q : '0;
							cumulative_count <= '0;
							query_valid      <= 1'b0;
							bad_frame        <= hit_c;
							total_vehicles   <= hit_c ? tot_inc_c : total_q;
						end
					end
				end
				S_SEG_WR: begin
					state_q          <= S_IDLE;
					done             <= 1'b1;
					crossed          <= 1'b1;
					crossing_frame   <= frame_q;
					cumulative_count <= '0;
					query_valid      <= 1'b0;
					bad_frame        <= 1'b0;
					total_vehicles   <= total_q;
				end
				S_QRY_RD: state_q <= S_QRY_DATA;
				S_QRY_DATA: begin
					state_q          <= S_IDLE;
					done             <= 1'b1;
					crossed          <= 1'b0;
					crossing_frame   <= '0;
					cumulative_count <= qv_q ? rd_data_s1 : '0;
					query_valid      <= qv_q;
					bad_frame        <= 1'b0;
					total_vehicles   <= total_q;
				end
				S_BUILD: begin
					// read ahead one entry while the previous one is summed and written
					bld_idx_q <= bld_idx_q + AW'(1);
					if (CW'(bld_idx_q) == used_m1_c)
						state_q <= S_BUILD_TAIL;
				end
				S_BUILD_TAIL: begin
					state_q          <= S_IDLE;
					done             <= 1'b1;
					crossed          <= 1'b0;
					crossing_frame   <= '0;
					cumulative_count <= run_c;
					query_valid      <= 1'b1;
					bad_frame        <= 1'b0;
					total_vehicles   <= total_q;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- hdl/glc_checker.sv -----
// Port-level checks for the gate line crossing counter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module glc_checker
	import glc_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  start,
	input wire logic                  busy,
	input wire logic                  done,
	input wire logic                  crossed,
	input wire logic [FRAME_BITS-1:0] crossing_frame,
	input wire logic                  query_valid,
	input wire logic                  bad_frame
);
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a request in flight");

	a_no_cross_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && !crossed |-> (crossing_frame == '0) && !bad_frame)
		else $error("crossing fields set on a non-crossing result");

	a_query_not_cross: assert property (@(posedge clk) disable iff (!arst_n)
		done && query_valid |-> !crossed)
		else $error("query result flagged as crossing");
endmodule

bind gate_line_crossing_counter glc_checker u_glc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.crossed        (crossed),
	.crossing_frame (crossing_frame),
	.query_valid    (query_valid),
	.bad_frame      (bad_frame)
);
`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking bench for the gate line crossing counter: directed and random request traffic.
`timescale 1ns / 1ps
module tb;
	import glc_pkg::*;

	localparam int RUN_LIMIT = 3_000_000;
	localparam int BIG_BUILD = 4096;

	typedef enum bit [1:0] {ACT_CLEAR, ACT_SEGMENT, ACT_BUILD, ACT_QUERY} action_e;
	typedef enum bit [CFG_IDX_BITS-1:0] {
		REG_GATE_X0, REG_GATE_Y0, REG_GATE_X1, REG_GATE_Y1, REG_FRAMES_IN_USE
	} reg_e;

	typedef struct {
		action_e                act;
		bit [FRAME_BITS-1:0]    frame;
		bit [COORD_BITS-1:0]    x0, y0, x1, y1;
		bit                     last;
		bit [FRAME_BITS-1:0]    qframe;
	} traffic_req_t;

	typedef struct packed {
		bit                     crossed;
		bit [FRAME_BITS-1:0]    cframe;
		bit [COUNT_BITS-1:0]    cum;
		bit                     qvalid;
		bit                     bad;
		bit [COUNT_BITS-1:0]    total;
	} count_report_t;

	localparam bit [COUNT_BITS-1:0] COUNT_SAT = '1;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [1:0]               action = '0;
	logic [FRAME_BITS-1:0]    seg_frame = '0;
	logic [COORD_BITS-1:0]    seg_x0 = '0;
	logic [COORD_BITS-1:0]    seg_y0 = '0;
	logic [COORD_BITS-1:0]    seg_x1 = '0;
	logic [COORD_BITS-1:0]    seg_y1 = '0;
	logic                     last_segment = 1'b0;
	logic [FRAME_BITS-1:0]    query_frame = '0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic                     done;
	logic                     crossed;
	logic [FRAME_BITS-1:0]    crossing_frame;
	logic [COUNT_BITS-1:0]    cumulative_count;
	logic                     query_valid;
	logic                     bad_frame;
	logic [COUNT_BITS-1:0]    total_vehicles;

	gate_line_crossing_counter dut (.*);

	always #5 clk = ~clk;

	// Mirror of the block's state
	bit [COORD_BITS-1:0] gate_ax, gate_ay, gate_bx, gate_by;
	bit [FIU_BITS-1:0]   table_size = FIU_BITS'(MAX_FRAMES_DEF);
	bit [COUNT_BITS-1:0] timeline [MAX_FRAMES_DEF];
	bit [COUNT_BITS-1:0] crossings_total;
	bit                  vehicle_done;

	count_report_t count_reports [$];
	count_report_t head_report;

	int  cycle_count, error_count;
	int  n_requests, n_settings, n_checked, n_crossings, n_bad, n_saturated;
	bit  idle_enabled, quiet_stretch;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	function automatic bit [COUNT_BITS-1:0] add_sat(input bit [COUNT_BITS-1:0] a, b);
		bit [COUNT_BITS:0] s;
		s = a + b;
		return s > COUNT_SAT ? COUNT_SAT : s[COUNT_BITS-1:0];
	endfunction

	function automatic int unsigned live_entries();
		return (table_size > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : table_size;
	endfunction

	function automatic bit in_range01(input longint n, d);
		if (d > 0)
			return n >= 0 && n <= d;
		return n <= 0 && n >= d;
	endfunction

	// Exact integer test of the bounded intersection; parallel or degenerate never meets
	function automatic bit hits_gate(input bit [COORD_BITS-1:0] sx0, sy0, sx1, sy1);
		longint ax, ay, bx, by, cx, cy, d;
		ax = longint'(gate_bx) - longint'(gate_ax);
		ay = longint'(gate_by) - longint'(gate_ay);
		bx = longint'(sx0) - longint'(sx1);
		by = longint'(sy0) - longint'(sy1);
		cx = longint'(gate_ax) - longint'(sx0);
		cy = longint'(gate_ay) - longint'(sy0);
		d = ay * bx - ax * by;
		if (d == 0)
			return 1'b0;
		return in_range01(by * cx - bx * cy, d) && in_range01(ax * cy - ay * cx, d);
	endfunction

	function automatic count_report_t tally_request(input traffic_req_t rq);
		count_report_t rep;
		int unsigned used;
		rep = '0;
		used = live_entries();
		case (rq.act)
			ACT_CLEAR: begin
				foreach (timeline[i])
					timeline[i] = '0;
				crossings_total = '0;
				vehicle_done = 1'b0;
			end
			ACT_SEGMENT: begin
				if (!vehicle_done && hits_gate(rq.x0, rq.y0, rq.x1, rq.y1)) begin
					vehicle_done = 1'b1;
					rep.crossed = 1'b1;
					rep.cframe = rq.frame;
					crossings_total = add_sat(crossings_total, 1);
					if (rq.frame < used)
						timeline[rq.frame] = add_sat(timeline[rq.frame], 1);
					else
						rep.bad = 1'b1;
				end
				if (rq.last)
					vehicle_done = 1'b0;
			end
			ACT_BUILD: begin
				for (int unsigned i = 1; i < used; i++)
					timeline[i] = add_sat(timeline[i-1], timeline[i]);
				if (used > 0) begin
					rep.cum = timeline[used-1];
					rep.qvalid = 1'b1;
				end
			end
			default: begin
				if (rq.qframe < used) begin
					rep.cum = timeline[rq.qframe];
					rep.qvalid = 1'b1;
				end
			end
		endcase
		rep.total = crossings_total;
		return rep;
	endfunction

	task automatic check_field(input string name, input longint unsigned want, got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endtask

	// Compare each result against the oldest outstanding request
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (count_reports.size() == 0) begin
				$error("result with no request outstanding");
				error_count++;
			end else begin
				head_report = count_reports.pop_front();
				check_field("crossed", head_report.crossed, crossed);
				check_field("crossing_frame", head_report.cframe, crossing_frame);
				check_field("cumulative_count", head_report.cum, cumulative_count);
				check_field("query_valid", head_report.qvalid, query_valid);
				check_field("bad_frame", head_report.bad, bad_frame);
				check_field("total_vehicles", head_report.total, total_vehicles);
				n_checked++;
				if (head_report.crossed)
					n_crossings++;
				if (head_report.bad)
					n_bad++;
				if (head_report.qvalid && head_report.cum == COUNT_SAT)
					n_saturated++;
			end
		end
	end

	task automatic pause_requests(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Hold off until every outstanding result is back and the block is idle
	task automatic drain_results();
		start <= 1'b0;
		while (count_reports.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_request(input traffic_req_t rq);
		if (idle_enabled) begin
			if ($urandom_range(0, 39) == 0)
				quiet_stretch = !quiet_stretch;
			if (!quiet_stretch && $urandom_range(0, 3) == 0)
				pause_requests($urandom_range(1, 13));
		end
		start <= 1'b1;
		action <= rq.act;
		seg_frame <= rq.frame;
		seg_x0 <= rq.x0;
		seg_y0 <= rq.y0;
		seg_x1 <= rq.x1;
		seg_y1 <= rq.y1;
		last_segment <= rq.last;
		query_frame <= rq.qframe;
		do @(posedge clk); while (busy);
		count_reports.push_back(tally_request(rq));
		n_requests++;
	endtask

	function automatic traffic_req_t noise_req();
		traffic_req_t rq;
		rq.act = action_e'($urandom_range(0, 3));
		rq.frame = $urandom;
		rq.x0 = $urandom;
		rq.y0 = $urandom;
		rq.x1 = $urandom;
		rq.y1 = $urandom;
		rq.last = $urandom;
		rq.qframe = $urandom;
		return rq;
	endfunction

	task automatic send_segment(input bit [FRAME_BITS-1:0] f,
			input bit [COORD_BITS-1:0] x0, y0, x1, y1, input bit last);
		traffic_req_t rq;
		rq = noise_req();
		rq.act = ACT_SEGMENT;
		rq.frame = f;
		rq.x0 = x0;
		rq.y0 = y0;
		rq.x1 = x1;
		rq.y1 = y1;
		rq.last = last;
		send_request(rq);
	endtask

	task automatic send_query(input bit [FRAME_BITS-1:0] f);
		traffic_req_t rq;
		rq = noise_req();
		rq.act = ACT_QUERY;
		rq.qframe = f;
		send_request(rq);
	endtask

	task automatic send_action(input action_e a);
		traffic_req_t rq;
		rq = noise_req();
		rq.act = a;
		send_request(rq);
	endtask

	task automatic write_reg(input reg_e idx, input bit [CFG_DATA_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_GATE_X0:       gate_ax = val[COORD_BITS-1:0];
			REG_GATE_Y0:       gate_ay = val[COORD_BITS-1:0];
			REG_GATE_X1:       gate_bx = val[COORD_BITS-1:0];
			REG_GATE_Y1:       gate_by = val[COORD_BITS-1:0];
			REG_FRAMES_IN_USE: table_size = val[FIU_BITS-1:0];
			default: ;
		endcase
	endtask

	// Put random junk above the coordinate bits; the block must mask it
	function automatic bit [CFG_DATA_BITS-1:0] with_junk(input int v);
		bit [CFG_DATA_BITS-1:0] w;
		w = $urandom;
		w[COORD_BITS-1:0] = v;
		return w;
	endfunction

	task automatic set_gate_table(input int gx0, gy0, gx1, gy1, input int unsigned size);
		drain_results();
		write_reg(REG_GATE_X0, with_junk(gx0));
		write_reg(REG_GATE_Y0, with_junk(gy0));
		write_reg(REG_GATE_X1, with_junk(gx1));
		write_reg(REG_GATE_Y1, with_junk(gy1));
		write_reg(REG_FRAMES_IN_USE, size);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	function automatic bit [COORD_BITS-1:0] clamp_coord(input int v);
		if (v < 0)
			return '0;
		if (v > (1 << COORD_BITS) - 1)
			return '1;
		return v;
	endfunction

	function automatic bit [FRAME_BITS-1:0] pick_frame();
		int unsigned used;
		used = live_entries();
		if (used > 0 && $urandom_range(0, 2) != 0)
			return $urandom_range(0, used - 1);
		return $urandom;
	endfunction

	// Mostly segments straddling a point on the gate, some anywhere
	function automatic traffic_req_t random_segment();
		traffic_req_t rq;
		int t, mx, my, dx, dy, span;
		rq = noise_req();
		rq.act = ACT_SEGMENT;
		rq.frame = pick_frame();
		if ($urandom_range(0, 9) < 6) begin
			case ($urandom_range(0, 5))
				0: t = 0;
				1: t = 256;
				default: t = $urandom_range(0, 256);
			endcase
			mx = int'(gate_ax) + (int'(gate_bx) - int'(gate_ax)) * t / 256;
			my = int'(gate_ay) + (int'(gate_by) - int'(gate_ay)) * t / 256;
			case ($urandom_range(0, 2))
				0: span = 2;
				1: span = 64;
				default: span = 2048;
			endcase
			dx = int'($urandom_range(0, 2 * span)) - span;
			dy = int'($urandom_range(0, 2 * span)) - span;
			rq.x0 = clamp_coord(mx + dx);
			rq.y0 = clamp_coord(my + dy);
			rq.x1 = clamp_coord(mx - dx);
			rq.y1 = clamp_coord(my - dy);
			// Land one end on the gate point
			if ($urandom_range(0, 4) == 0) begin
				rq.x0 = clamp_coord(mx);
				rq.y0 = clamp_coord(my);
			end
		end
		return rq;
	endfunction

	task automatic test_reset_state();
		drain_results();
		send_query(0);
		send_query(16'hFFFF);
		// Gate is a single point after reset
		send_segment(0, 0, 0, 4095, 4095, 1'b1);
		send_action(ACT_BUILD);
	endtask

	task automatic test_gate_geometry();
		set_gate_table(0, 0, 4095, 4095, 16);
		send_segment(3, 0, 4095, 4095, 0, 1'b0);
		// Same vehicle meets the gate again: not counted twice
		send_segment(4, 0, 4095, 4095, 0, 1'b1);
		send_segment(15, 4095, 4095, 4095, 0, 1'b1);
		send_segment(5, 1, 0, 4095, 4094, 1'b1);
		send_segment(6, 0, 0, 100, 100, 1'b1);
		send_segment(7, 200, 300, 200, 300, 1'b1);
		send_segment(16, 0, 4095, 4095, 0, 1'b1);
		send_segment(16'hFFFF, 0, 4095, 4095, 0, 1'b1);
		send_segment(8, 4095, 0, 2047, 2046, 1'b1);
		send_query(3);
		send_query(15);
		send_query(16);
		send_action(ACT_BUILD);
		send_action(ACT_CLEAR);
		send_query(15);
	endtask

	task automatic test_table_size_extremes();
		set_gate_table(4095, 0, 0, 4095, 0);
		send_segment(0, 0, 0, 4095, 4095, 1'b1);
		send_query(0);
		send_action(ACT_BUILD);
		set_gate_table(4095, 0, 0, 4095, 1);
		send_segment(0, 0, 0, 4095, 4095, 1'b1);
		send_segment(1, 0, 0, 4095, 4095, 1'b1);
		send_action(ACT_BUILD);
		send_query(0);
		set_gate_table(0, 2048, 4095, 2048, 131071);
		send_segment(16'hFFFF, 100, 0, 100, 4095, 1'b1);
		send_query(16'hFFFF);
	endtask

	task automatic run_traffic(input int n_items, input bit clear_first);
		traffic_req_t rq;
		int sent, nseg, pick;
		bit [FRAME_BITS-1:0] base;
		bit builds_ok;
		sent = 0;
		builds_ok = live_entries() <= BIG_BUILD;
		if (clear_first) begin
			send_action(ACT_CLEAR);
			sent++;
		end
		while (sent < n_items) begin
			if ($urandom_range(0, 149) == 0)
				drain_results();
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				nseg = $urandom_range(1, 6);
				base = pick_frame();
				for (int k = 0; k < nseg; k++) begin
					rq = random_segment();
					rq.frame = base + FRAME_BITS'(k);
					// Now and then a vehicle runs into the next one
					rq.last = (k == nseg - 1) && ($urandom_range(0, 9) != 0);
					send_request(rq);
				end
				sent += nseg;
			end else if (pick < 85 || (pick < 93 && !builds_ok)) begin
				send_query(pick_frame());
				sent++;
			end else if (pick < 93) begin
				send_action(ACT_BUILD);
				sent++;
			end else begin
				send_request(random_segment());
				sent++;
			end
		end
	endtask

	task automatic test_random_traffic();
		int unsigned size;
		int gx0, gy0, gx1, gy1, style;
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				1: size = 0;
				2: size = $urandom_range(200, 600);
				3: size = $urandom_range(1, 8);
				4: size = $urandom_range(MAX_FRAMES_DEF, 131071);
				default: size = $urandom_range(16, 64);
			endcase
			gx0 = $urandom_range(0, 4095);
			gy0 = $urandom_range(0, 4095);
			gx1 = $urandom_range(0, 4095);
			gy1 = $urandom_range(0, 4095);
			style = (ph == 0) ? 0 : $urandom_range(0, 4);
			case (style)
				1: gy1 = gy0;
				2: gx1 = gx0;
				3: begin
					gx0 = 4095 * $urandom_range(0, 1);
					gy0 = 4095 * $urandom_range(0, 1);
					gx1 = 4095 - gx0;
					gy1 = 4095 * $urandom_range(0, 1);
				end
				4: begin
					gx1 = gx0;
					gy1 = gy0;
				end
				default: ;
			endcase
			set_gate_table(gx0, gy0, gx1, gy1, size);
			idle_enabled = (ph != 6);
			quiet_stretch = 1'b0;
			run_traffic(ph == 1 ? 60 : 220, ph == 1 || ph == 4);
		end
		idle_enabled = 1'b0;
	endtask

	initial begin
		wait (cycle_count >= RUN_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_state();
		test_gate_geometry();
		test_table_size_extremes();
		test_random_traffic();
		drain_results();
		repeat (20) @(posedge clk);
		if (count_reports.size() != 0) begin
			$error("%0d results never arrived", count_reports.size());
			error_count++;
		end
		$display("Run covered %0d requests over %0d gate and table settings, %0d results checked.",
			n_requests, n_settings, n_checked);
		$display("Counted %0d crossings, %0d outside the table, %0d saturated sums.",
			n_crossings, n_bad, n_saturated);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
